[hdl/msf_pkg.sv]
// shared types, widths and constants for the median / weighted / slew filter
// no dependencies; used by msf_cell, msf_average and the top level
package msf_pkg;

   localparam int MEDIAN_TAPS_DEFAULT = 5;

   localparam int POS_W       = 8;
   localparam int STEP_W      = 7;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_POSITION_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STEP      = 1'b1;

   localparam logic [POS_W-1:0]  RESET_POSITION_LIMIT = 8'd100;
   localparam logic [STEP_W-1:0] RESET_RAMP_STEP      = 7'd5;

   // weighted sum 5*a + 3*b + 2*c stays below 2560
   localparam int SUM_W  = 12;
   localparam int PROD_W = 2 * SUM_W;
   localparam logic [SUM_W-1:0] WEIGHT_NEWEST = 12'd5;
   localparam logic [SUM_W-1:0] WEIGHT_MIDDLE = 12'd3;
   localparam logic [SUM_W-1:0] WEIGHT_OLDEST = 12'd2;

   // divide by ten as multiply by 3277 / 2^15, exact for sums below 2560
   localparam logic [SUM_W-1:0] DIV10_RECIP = 12'd3277;
   localparam int               DIV10_SHIFT = 15;

   typedef struct packed {
      logic [POS_W-1:0] value;
      logic             is_median;
   } msf_tap_type;

endpackage

[hdl/msf_cell.sv]
// one tap of the sample window: holds a clamped sample, shifts it on to the next
// tap and ranks itself against the whole window; depends on msf_pkg
module msf_cell #(
   parameter int TAPS  = msf_pkg::MEDIAN_TAPS_DEFAULT,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift_en,
   input  logic [msf_pkg::POS_W-1:0]            shift_in,
   input  logic [TAPS-1:0][msf_pkg::POS_W-1:0]  window,
   output msf_pkg::msf_tap_type                 tap
);

   localparam int RANK_W = $clog2(TAPS);

   logic [msf_pkg::POS_W-1:0] value_ff;
   logic [msf_pkg::POS_W-1:0] value_in;
   logic [RANK_W-1:0]         rank;

   assign value_in = shift_en ? shift_in : value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   // stable rank: equal values are ordered by tap position
   always_comb begin
      rank = '0;
      for (int j = 0; j < TAPS; j++) begin
         if (j != INDEX) begin
            if ((window[j] < value_ff) || ((window[j] == value_ff) && (j < INDEX))) begin
               rank = rank + RANK_W'(1);
            end
         end
      end
   end

   assign tap.value     = value_ff;
   assign tap.is_median = (rank == RANK_W'(TAPS / 2));

endmodule

[hdl/msf_average.sv]
// weighted 5,3,2 average of the three latest medians, divided by ten
// depends on msf_pkg
module msf_average (
   input  logic [msf_pkg::POS_W-1:0] newest,
   input  logic [msf_pkg::POS_W-1:0] middle,
   input  logic [msf_pkg::POS_W-1:0] oldest,
   output logic [msf_pkg::POS_W-1:0] average
);

   localparam int PAD_W = msf_pkg::SUM_W - msf_pkg::POS_W;

   logic [msf_pkg::SUM_W-1:0]  sum;
   logic [msf_pkg::PROD_W-1:0] prod;

   assign sum = ({{PAD_W{1'b0}}, newest} * msf_pkg::WEIGHT_NEWEST)
              + ({{PAD_W{1'b0}}, middle} * msf_pkg::WEIGHT_MIDDLE)
              + ({{PAD_W{1'b0}}, oldest} * msf_pkg::WEIGHT_OLDEST);

   // reciprocal multiply replaces the divide by ten
   assign prod = {{msf_pkg::SUM_W{1'b0}}, sum}
               * {{msf_pkg::SUM_W{1'b0}}, msf_pkg::DIV10_RECIP};

   assign average = prod[msf_pkg::DIV10_SHIFT +: msf_pkg::POS_W];

endmodule

[hdl/median_weighted_slew_filter_unit.sv]
// median / weighted-average / slew filter; one transaction in, one result out
// registered window, median, average and output stages lead to rsp_valid; throughput
// one per cycle unless rsp_stall holds it; the slew update feeds the output register
// reset (synchronous): window, median history and output position clear to zero,
// position_limit to 100, ramp_step to 5; no clearing pass
// depends on msf_pkg, msf_cell, msf_average
module median_weighted_slew_filter_unit #(
   parameter int MEDIAN_TAPS = msf_pkg::MEDIAN_TAPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [msf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [msf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [msf_pkg::POS_W-1:0]           req_raw_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [msf_pkg::POS_W-1:0]           rsp_median_value,
   output logic [msf_pkg::POS_W-1:0]           rsp_filtered_position,
   output logic [msf_pkg::POS_W-1:0]           rsp_output_position
);

   localparam int W = msf_pkg::POS_W;

   // configuration
   logic [W-1:0]               position_limit_ff, position_limit_in;
   logic [msf_pkg::STEP_W-1:0] ramp_step_ff, ramp_step_in;

   // stage valids: window, median, average, output
   logic win_valid_ff, win_valid_in;
   logic med_valid_ff, med_valid_in;
   logic avg_valid_ff, avg_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, load_med, load_avg, load_rsp;

   logic [W-1:0] sample;
   logic [W-1:0] median;
   logic [MEDIAN_TAPS-1:0][W-1:0] window;
   logic [MEDIAN_TAPS-1:0]        median_flags;
   msf_pkg::msf_tap_type          taps [MEDIAN_TAPS];

   logic [W-1:0] med2_ff, med2_in;
   logic [W-1:0] hist0_ff, hist0_in;
   logic [W-1:0] hist1_ff, hist1_in;
   logic [W-1:0] med3_ff, med3_in;
   logic [W-1:0] avg3_ff, avg3_in;
   logic [W-1:0] average;

   logic [W-1:0] rsp_median_value_ff, rsp_median_value_in;
   logic [W-1:0] rsp_filtered_position_ff, rsp_filtered_position_in;
   logic [W-1:0] rsp_output_position_ff, rsp_output_position_in;
   logic signed [W+1:0] diff;
   logic signed [W+1:0] step_s;

   // ---------------- handshake ----------------
   assign load_rsp = avg_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign load_avg = med_valid_ff && (!avg_valid_ff || load_rsp);
   assign load_med = win_valid_ff && (!med_valid_ff || load_avg);
   assign req_stall = win_valid_ff && !load_med;
   assign accept   = req_valid && !req_stall;

   assign win_valid_in = accept   || (win_valid_ff && !load_med);
   assign med_valid_in = load_med || (med_valid_ff && !load_avg);
   assign avg_valid_in = load_avg || (avg_valid_ff && !load_rsp);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   // ---------------- configuration ----------------
   always_comb begin
      position_limit_in = position_limit_ff;
      ramp_step_in      = ramp_step_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            msf_pkg::CSR_POSITION_LIMIT: position_limit_in = csr_wdata;
            msf_pkg::CSR_RAMP_STEP:      ramp_step_in = csr_wdata[msf_pkg::STEP_W-1:0];
         endcase
      end
   end

   // ---------------- sample window ----------------
   assign sample = (req_raw_position > position_limit_ff) ? position_limit_ff
                                                           : req_raw_position;

   for (genvar i = 0; i < MEDIAN_TAPS; i++) begin : g_tap
      logic [W-1:0] cell_in;
      if (i == 0) begin : g_head
         assign cell_in = sample;
      end else begin : g_link
         assign cell_in = taps[i-1].value;
      end
      msf_cell #(
         .TAPS  (MEDIAN_TAPS),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .shift_in (cell_in),
         .window   (window),
         .tap      (taps[i])
      );
      assign window[i]       = taps[i].value;
      assign median_flags[i] = taps[i].is_median;
   end

   // exactly one tap carries the middle rank
   always_comb begin
      median = '0;
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
         median = median | (median_flags[i] ? window[i] : '0);
      end
   end

   // ---------------- median, history and average ----------------
   msf_average u_average (
      .newest  (med2_ff),
      .middle  (hist0_ff),
      .oldest  (hist1_ff),
      .average (average)
   );

   assign med2_in  = load_med ? median : med2_ff;
   assign hist0_in = load_avg ? med2_ff : hist0_ff;
   assign hist1_in = load_avg ? hist0_ff : hist1_ff;
   assign med3_in  = load_avg ? med2_ff : med3_ff;
   assign avg3_in  = load_avg ? average : avg3_ff;

   // ---------------- slew limiter ----------------
   assign diff   = $signed({2'b00, avg3_ff}) - $signed({2'b00, rsp_output_position_ff});
   assign step_s = $signed({3'b000, ramp_step_ff});

   always_comb begin
      rsp_median_value_in      = rsp_median_value_ff;
      rsp_filtered_position_in = rsp_filtered_position_ff;
      rsp_output_position_in   = rsp_output_position_ff;
      if (load_rsp) begin
         rsp_median_value_in      = med3_ff;
         rsp_filtered_position_in = avg3_ff;
         priority if (diff > step_s) begin
            rsp_output_position_in = rsp_output_position_ff + {1'b0, ramp_step_ff};
         end else if (diff < -step_s) begin
            rsp_output_position_in = rsp_output_position_ff - {1'b0, ramp_step_ff};
         end else begin
            rsp_output_position_in = avg3_ff;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         position_limit_ff      <= msf_pkg::RESET_POSITION_LIMIT;
         ramp_step_ff           <= msf_pkg::RESET_RAMP_STEP;
         win_valid_ff           <= 1'b0;
         med_valid_ff           <= 1'b0;
         avg_valid_ff           <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         hist0_ff               <= '0;
         hist1_ff               <= '0;
         rsp_output_position_ff <= '0;
      end else begin
         position_limit_ff      <= position_limit_in;
         ramp_step_ff           <= ramp_step_in;
         win_valid_ff           <= win_valid_in;
         med_valid_ff           <= med_valid_in;
         avg_valid_ff           <= avg_valid_in;
         rsp_valid_ff           <= rsp_valid_in;
         hist0_ff               <= hist0_in;
         hist1_ff               <= hist1_in;
         rsp_output_position_ff <= rsp_output_position_in;
      end
   end

   always_ff @(posedge clock) begin
      med2_ff                  <= med2_in;
      med3_ff                  <= med3_in;
      avg3_ff                  <= avg3_in;
      rsp_median_value_ff      <= rsp_median_value_in;
      rsp_filtered_position_ff <= rsp_filtered_position_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_median_value      = rsp_median_value_ff;
   assign rsp_filtered_position = rsp_filtered_position_ff;
   assign rsp_output_position   = rsp_output_position_ff;

   // ---------------- assertions ----------------
   a_one_median : assert property (@(posedge clock) disable iff (reset)
      $onehot(median_flags))
      else $error("median rank not held by exactly one tap");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (win_valid_ff && med_valid_ff && avg_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while the pipeline has room");

   a_slew_bound : assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> ((rsp_output_position_ff >= $past(rsp_output_position_ff)) ?
         ((rsp_output_position_ff - $past(rsp_output_position_ff)) <= {1'b0, $past(ramp_step_ff)}) :
         (($past(rsp_output_position_ff) - rsp_output_position_ff) <= {1'b0, $past(ramp_step_ff)})))
      else $error("output position moved by more than ramp_step");

endmodule
